// File: sv/bls_pkg.sv
// Package for the battery level smoother: payload, config and state types, codes.
// No dependencies; every other file but bls_adc_map takes names from here by scope.
`timescale 1ns / 1ps
`default_nettype none

package bls_pkg;

  localparam int TIME_BITS_DEF = 32;

  localparam logic [3:0] MAX_MISSES_RST = 4'd5;
  localparam logic [7:0] GAP_SECONDS_RST = 8'd15;
  localparam logic [6:0] LEVEL_MAX = 7'd100;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_PMIC_MODE   = 2'd0,
    CFG_MAX_MISSES  = 2'd1,
    CFG_GAP_SECONDS = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic        gauge_ok;
    logic [7:0]  gauge_byte;
    logic        status_ok;
    logic [7:0]  status_byte;
    logic [9:0]  sar_sample;
    logic        charger_pin;
    logic        time_ok;
    logic [31:0] now_seconds;
  } item_t;

  typedef struct packed {
    logic       published;
    logic [6:0] level;
    logic       charging;
  } result_t;

  typedef struct packed {
    logic       pmic_mode;
    logic [3:0] max_misses;
    logic [7:0] gap_seconds;
  } cfg_t;

  // Everything the smoother carries between ticks except the time stamp
  typedef struct packed {
    logic [6:0] held_level;
    logic       held_level_known;
    logic [3:0] miss_count;
    logic       held_power;
    logic       held_power_known;
    logic       power_now;
    logic       first_pass;
    logic [6:0] eased_level;
  } state_t;

endpackage

`default_nettype wire

// File: sv/bls_adc_map.sv
// Piecewise-linear map of the raw SAR sample to a 0..100 percentage.
// Pure combinational; no package use.
`timescale 1ns / 1ps
`default_nettype none

module bls_adc_map (
  input  wire logic [9:0] sample,
  output logic      [6:0] level
);

  logic [9:0]  upper;
  logic [14:0] mid;
  logic [4:0]  k;

  always_comb begin
    upper = sample - 10'd478;
    // 17*s - 8544, then truncate by 8; positive throughout this band
    mid   = ({1'b0, sample, 4'b0000} + {5'b00000, sample}) - 15'd8544;
    k     = sample[4:0];
    if (sample >= 10'd528) begin
      level = (upper > 10'd100) ? 7'd100 : upper[6:0];
    end else if (sample >= 10'd512) begin
      level = mid[9:3];
    end else if (sample >= 10'd480) begin
      // 0.51613*s - 243.742 over 480..511 is 4.0004 + 0.51613*k:
      // floor gives 4 + k/2, plus one at the top code
      level = 7'd4 + {3'b000, k[4:1]} + {6'b0, (k == 5'd31)};
    end else begin
      level = 7'd0;
    end
  end

endmodule

`default_nettype wire

// File: sv/bls_step.sv
// Next-state and result logic for one tick of the battery level smoother.
// Uses bls_pkg types and bls_adc_map.
`timescale 1ns / 1ps
`default_nettype none

module bls_step #(
  parameter int TIME_BITS = bls_pkg::TIME_BITS_DEF
) (
  input  wire bls_pkg::item_t   item,
  input  wire bls_pkg::cfg_t    cfg,
  input  wire bls_pkg::state_t  state,
  input  wire logic [((TIME_BITS < 32) ? TIME_BITS : 32)-1:0] tick_stamp,
  output bls_pkg::state_t       state_next,
  output logic [((TIME_BITS < 32) ? TIME_BITS : 32)-1:0] tick_stamp_next,
  output bls_pkg::result_t      result
);

  localparam int TW = (TIME_BITS < 32) ? TIME_BITS : 32;

  logic [6:0]    adc_level;
  logic [6:0]    gauge;
  logic          gauge_good;
  logic [4:0]    miss_inc;
  logic [6:0]    cur;
  logic          cur_ok;
  logic          power;
  logic [TW-1:0] now_t;
  logic [TW-1:0] diff;
  logic          gap;
  logic          snap;

  bls_adc_map u_adc (
    .sample (item.sar_sample),
    .level  (adc_level)
  );

  always_comb begin
    state_next      = state;
    tick_stamp_next = tick_stamp;
    gauge           = item.gauge_byte[6:0];
    gauge_good      = item.gauge_ok && (gauge <= bls_pkg::LEVEL_MAX);
    miss_inc        = {1'b0, state.miss_count} + 5'd1;
    now_t           = item.now_seconds[TW-1:0];
    diff            = now_t - tick_stamp;
    cur             = adc_level;
    cur_ok          = 1'b1;
    power           = item.charger_pin;
    gap             = 1'b0;
    snap            = 1'b0;

    // Level source
    if (cfg.pmic_mode) begin
      cur = state.held_level;
      if (gauge_good) begin
        cur                         = gauge;
        state_next.miss_count       = 4'd0;
        state_next.held_level       = gauge;
        state_next.held_level_known = 1'b1;
      end else if (state.held_level_known) begin
        state_next.miss_count = miss_inc[4] ? 4'd15 : miss_inc[3:0];
        cur_ok                = (miss_inc <= {1'b0, cfg.max_misses});
      end else begin
        cur_ok = 1'b0;
      end
    end

    result.published = cur_ok;
    result.level     = state.eased_level;
    result.charging  = state.power_now;

    if (cur_ok) begin
      if (cfg.pmic_mode) begin
        if (item.status_ok) begin
          power                       = item.status_byte[7] | item.status_byte[4];
          state_next.held_power       = power;
          state_next.held_power_known = 1'b1;
        end else begin
          power = state.held_power_known & state.held_power;
        end
      end
      state_next.power_now = power;

      if (item.time_ok) begin
        // stored zero means no stamp yet; a backward step is not a gap
        gap = (tick_stamp != '0) && (now_t >= tick_stamp) &&
              (diff >= TW'(cfg.gap_seconds));
        tick_stamp_next = now_t;
      end

      snap = state.first_pass || gap || (state.power_now && !power);
      if (snap) begin
        state_next.first_pass  = 1'b0;
        state_next.eased_level = cur;
      end else if (state.eased_level < cur) begin
        state_next.eased_level = state.eased_level + 7'd1;
      end else if (state.eased_level > cur) begin
        state_next.eased_level = state.eased_level - 7'd1;
      end

      result.level    = state_next.eased_level;
      result.charging = power;
    end
  end

endmodule

`default_nettype wire

// File: sv/battery_level_smoother.sv
// Battery level smoother, top level: item register, per-tick logic, result register.
// Depends on bls_pkg, bls_step and bls_adc_map.
//
// One battery check enters per clock and one result leaves per clock when the
// consumer does not stall. The item first waits in the item register, then the
// tick logic updates the smoother state as the item moves into the result
// register. The result register decouples the two sides, so a new item is
// taken while a finished result waits, and once the item register is occupied
// a stall on the result side backs up into item_stall in the same cycle.
// Configuration writes are always ready and should be issued only while no
// item is in flight.
`timescale 1ns / 1ps
`default_nettype none

module battery_level_smoother #(
  parameter int TIME_BITS = bls_pkg::TIME_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_stall,
  input  wire bls_pkg::item_t   item,
  output logic                  result_valid,
  input  wire logic             result_stall,
  output bls_pkg::result_t      result,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [7:0]       cfg_data
);

  localparam int TW = (TIME_BITS < 32) ? TIME_BITS : 32;

  bls_pkg::cfg_t    cfg;
  bls_pkg::state_t  state;
  bls_pkg::state_t  state_next;
  logic [TW-1:0]    tick_stamp;
  logic [TW-1:0]    tick_stamp_next;
  logic             hold_valid;
  bls_pkg::item_t   hold_item;
  bls_pkg::result_t step_result;
  logic             advance;

  assign cfg_ready  = 1'b1;
  assign advance    = hold_valid && (!result_valid || !result_stall);
  assign item_stall = hold_valid && !advance;

  bls_step #(.TIME_BITS(TIME_BITS)) u_step (
    .item            (hold_item),
    .cfg             (cfg),
    .state           (state),
    .tick_stamp      (tick_stamp),
    .state_next      (state_next),
    .tick_stamp_next (tick_stamp_next),
    .result          (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pmic_mode   <= 1'b0;
      cfg.max_misses  <= bls_pkg::MAX_MISSES_RST;
      cfg.gap_seconds <= bls_pkg::GAP_SECONDS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (bls_pkg::cfg_index_t'(cfg_index))
        bls_pkg::CFG_PMIC_MODE:   cfg.pmic_mode   <= cfg_data[0];
        bls_pkg::CFG_MAX_MISSES:  cfg.max_misses  <= cfg_data[3:0];
        bls_pkg::CFG_GAP_SECONDS: cfg.gap_seconds <= cfg_data;
        default: ;
      endcase
    end
  end

  // Item register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!item_stall) begin
      hold_valid <= item_valid;
    end
    if (!item_stall && item_valid) begin
      hold_item <= item;
    end
  end

  // Smoother state moves only when a tick transfers into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= '{first_pass: 1'b1, default: '0};
      tick_stamp <= '0;
    end else if (advance) begin
      state      <= state_next;
      tick_stamp <= tick_stamp_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (advance) begin
      result <= step_result;
    end
  end

endmodule

`default_nettype wire

// File: sv/bls_checker.sv
// Port-level checks for battery_level_smoother, attached by bind.
// Depends on bls_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none

module bls_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             item_valid,
  input wire logic             item_stall,
  input wire logic             result_valid,
  input wire logic             result_stall,
  input wire bls_pkg::result_t result
);

  // A stalled result stays and holds its payload
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed or dropped");

  // Reset empties the result register
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  // A fresh result needs an item transfer that went through the item register first
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    result_valid && !$past(result_valid) |->
      $past(item_valid, 2) && !$past(item_stall, 2))
    else $error("result appeared without a matching item transfer");

endmodule

bind battery_level_smoother bls_checker u_bls_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

`default_nettype wire
